@@ src/dpt_pkg.sv @@
package dpt_pkg;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned BOUNDARY_LOG2   = 16;
  localparam int unsigned ALIGN_LOG2      = 1;
  localparam int unsigned ADDR_LIMIT_BITS = 32;
  localparam int unsigned MAX_SPAN        = 65536;

  localparam int unsigned SECTOR_COUNT_W = 16;
  localparam int unsigned PHYS_ADDR_W    = 40;
  localparam int unsigned PAIR_BYTES_W   = 20;
  localparam int unsigned ENTRY_ADDR_W   = 32;
  localparam int unsigned ENTRY_BYTES_W  = 16;
  localparam int unsigned STATUS_W       = 2;

  localparam int unsigned REM_W         = 25;
  localparam int unsigned BUDGET_FULL_W = SECTOR_COUNT_W + $clog2(SECTOR_BYTES + 1);
  localparam int unsigned SPAN_CMP_W    = PAIR_BYTES_W + 1;
  localparam int unsigned FIRST_W       = BOUNDARY_LOG2 + 1;
  localparam int unsigned CMP_W         = (FIRST_W > PAIR_BYTES_W) ? FIRST_W : PAIR_BYTES_W;

  localparam logic [REM_W-1:0]       BUDGET_MAX = '1;
  localparam logic [PHYS_ADDR_W-1:0] ALIGN_MASK =
    PHYS_ADDR_W'((64'd1 << ALIGN_LOG2) - 64'd1);

  localparam int unsigned IN_TDATA_W  =
    ((SECTOR_COUNT_W + PHYS_ADDR_W + PAIR_BYTES_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W =
    ((ENTRY_ADDR_W + ENTRY_BYTES_W + 1 + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_ADDR_HIGH  = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_SPAN_LARGE = 2'd3
  } status_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_PAIR  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [SECTOR_COUNT_W-1:0] sector_count;
    logic [PHYS_ADDR_W-1:0]    phys_address;
    logic [PAIR_BYTES_W-1:0]   pair_bytes;
    logic                      last_pair;
  } item_t;

  typedef struct packed {
    logic [ENTRY_ADDR_W-1:0]  entry_address;
    logic [ENTRY_BYTES_W-1:0] entry_bytes;
    logic                     end_of_table;
    status_e                  status;
    logic                     last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]       num_results;
    result_t          res0;
    result_t          res1;
    logic [REM_W-1:0] rem_next;
    logic             aborted_next;
  } calc_out_t;

endpackage

@@ src/dpt_calc.sv @@
module dpt_calc (
  input  dpt_pkg::item_t            item_i,
  input  logic [dpt_pkg::REM_W-1:0] rem_i,
  input  logic                      aborted_i,
  output dpt_pkg::calc_out_t        calc_o
);
  import dpt_pkg::*;

  logic [BUDGET_FULL_W-1:0] budget_full;
  logic                     addr_high;
  logic                     addr_misaligned;
  logic                     span_large;
  logic                     len_misaligned;
  status_e                  status;
  logic [PAIR_BYTES_W-1:0]  clip;
  logic [FIRST_W-1:0]       first;
  logic                     split;

  assign budget_full = BUDGET_FULL_W'(item_i.sector_count) * BUDGET_FULL_W'(SECTOR_BYTES);

  assign addr_high       = (item_i.phys_address >> ADDR_LIMIT_BITS) != '0;
  assign addr_misaligned = (item_i.phys_address & ALIGN_MASK) != '0;
  assign span_large      = SPAN_CMP_W'(item_i.pair_bytes) > SPAN_CMP_W'(MAX_SPAN);
  assign len_misaligned  = (item_i.pair_bytes & ALIGN_MASK[PAIR_BYTES_W-1:0]) != '0;

  always_comb begin
    if (addr_high) begin
      status = ST_ADDR_HIGH;
    end else if (addr_misaligned) begin
      status = ST_MISALIGNED;
    end else if (span_large) begin
      status = ST_SPAN_LARGE;
    end else if (len_misaligned) begin
      status = ST_MISALIGNED;
    end else begin
      status = ST_OK;
    end
  end

  assign clip  = (REM_W'(item_i.pair_bytes) < rem_i) ? item_i.pair_bytes
                                                      : rem_i[PAIR_BYTES_W-1:0];
  assign first = FIRST_W'(64'd1 << BOUNDARY_LOG2)
               - FIRST_W'(item_i.phys_address[BOUNDARY_LOG2-1:0]);
  assign split = CMP_W'(clip) > CMP_W'(first);

  always_comb begin
    calc_o              = '0;
    calc_o.rem_next     = rem_i;
    calc_o.aborted_next = aborted_i;
    calc_o.res0.status  = ST_OK;
    calc_o.res1.status  = ST_OK;
    if (item_i.kind == KIND_START) begin
      calc_o.aborted_next = 1'b0;
      if (budget_full > BUDGET_FULL_W'(BUDGET_MAX)) begin
        calc_o.rem_next = BUDGET_MAX;
      end else begin
        calc_o.rem_next = budget_full[REM_W-1:0];
      end
    end else if (!aborted_i) begin
      if (status != ST_OK) begin
        calc_o.aborted_next     = 1'b1;
        calc_o.num_results      = 2'd1;
        calc_o.res0.status      = status;
        calc_o.res0.last_of_run = 1'b1;
      end else if (clip != '0) begin
        calc_o.rem_next           = rem_i - REM_W'(clip);
        calc_o.res0.entry_address = item_i.phys_address[ENTRY_ADDR_W-1:0];
        if (split) begin
          calc_o.num_results        = 2'd2;
          calc_o.res0.entry_bytes   = first[ENTRY_BYTES_W-1:0];
          calc_o.res1.entry_address = item_i.phys_address[ENTRY_ADDR_W-1:0]
                                    + ENTRY_ADDR_W'(first);
          calc_o.res1.entry_bytes   = ENTRY_BYTES_W'(CMP_W'(clip) - CMP_W'(first));
          calc_o.res1.end_of_table  = item_i.last_pair;
          calc_o.res1.last_of_run   = 1'b1;
        end else begin
          calc_o.num_results       = 2'd1;
          calc_o.res0.entry_bytes  = clip[ENTRY_BYTES_W-1:0];
          calc_o.res0.end_of_table = item_i.last_pair;
          calc_o.res0.last_of_run  = 1'b1;
        end
      end
    end
  end

endmodule

@@ src/dma_prd_table_builder_unit.sv @@
// Descriptor table builder for bus-master DMA.
// Input stream (s_axis): tuser is the item kind (0 start, 1 pair), tlast marks
// the final pair of a transfer, tdata carries sector count, address and length.
// A start transaction loads the byte budget and gives no result. A pair
// transaction gives one error result, one entry, two entries (split at a
// 64 KiB boundary) or nothing once the transfer is aborted or the budget is spent.
// Output stream (m_axis): tdata carries entry address, byte count (0 = 65536)
// and the end-of-table flag; tuser is the status; tlast marks the last result
// of the input transaction.
// Results are registered: the first is on m_axis in the cycle after acceptance.
// Throughput: one transaction per cycle while each gives at most one result
// and the receiver is ready; a pair that splits into two entries holds the
// input until the single output port drains the first of the two buffered entries.
// Reset clears the budget, the abort flag and the result buffer.
// When the receiver stalls, results hold in the buffer and s_axis_tready_o
// drops once a result is waiting that is not being taken.
module dma_prd_table_builder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] sector_count, [55:16] phys_address, [75:56] pair_bytes, [79:76] zero
  input  logic [dpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] kind
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] entry_address, [47:32] entry_bytes, [48] end_of_table, [55:49] zero
  output logic [dpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [dpt_pkg::STATUS_W-1:0]    m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import dpt_pkg::*;

  item_t            item;
  calc_out_t        calc;
  logic             in_acc;
  logic             out_acc;
  logic [1:0]       count_q, count_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             aborted_q, aborted_d;
  result_t          slot0_q, slot0_d;
  result_t          slot1_q, slot1_d;

  assign item.kind         = kind_e'(s_axis_tuser_i);
  assign item.sector_count = s_axis_tdata_i[SECTOR_COUNT_W-1:0];
  assign item.phys_address = s_axis_tdata_i[SECTOR_COUNT_W +: PHYS_ADDR_W];
  assign item.pair_bytes   = s_axis_tdata_i[SECTOR_COUNT_W + PHYS_ADDR_W +: PAIR_BYTES_W];
  assign item.last_pair    = s_axis_tlast_i;

  dpt_calc u_calc (
    .item_i    (item),
    .rem_i     (rem_q),
    .aborted_i (aborted_q),
    .calc_o    (calc)
  );

  assign m_axis_tvalid_o = count_q != 2'd0;
  assign s_axis_tready_o = (count_q == 2'd0) || ((count_q == 2'd1) && m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  assign m_axis_tdata_o = OUT_TDATA_W'({slot0_q.end_of_table, slot0_q.entry_bytes,
                                        slot0_q.entry_address});
  assign m_axis_tuser_o = slot0_q.status;
  assign m_axis_tlast_o = slot0_q.last_of_run;

  always_comb begin
    count_d   = count_q;
    rem_d     = rem_q;
    aborted_d = aborted_q;
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    if (in_acc) begin
      // buffer is empty or drains this cycle
      count_d   = calc.num_results;
      rem_d     = calc.rem_next;
      aborted_d = calc.aborted_next;
      slot0_d   = calc.res0;
      slot1_d   = calc.res1;
    end else if (out_acc) begin
      count_d = count_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 2'd0;
      rem_q     <= '0;
      aborted_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rem_q     <= rem_d;
      aborted_q <= aborted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !s_axis_tready_o)
    else $error("input accepted with result buffer full");

  a_budget_never_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == KIND_PAIR) |=> (rem_q <= $past(rem_q)))
    else $error("pair transaction raised the byte budget");

  a_error_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_OK) |->
      (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("error result with payload or without last flag");

  a_aborted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && aborted_q && s_axis_tuser_i == KIND_PAIR) |=> (count_q == 2'd0))
    else $error("result emitted for a pair of an aborted transfer");

endmodule

@@ tb/sv/dma_prd_table_builder_unit_test.sv @@
`timescale 1ns / 1ps

module dma_prd_table_builder_unit_test;
  import dpt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned RANDOM_ITEMS   = 400;

  typedef struct {
    item_t   it;
    bit      typed;
    int      n_typed;
    result_t res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   s_axis_tlast_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  dma_prd_table_builder_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  logic [REM_W-1:0] budget_q = '0;
  bit               aborted_q = 1'b0;
  result_t          entry_q[$];
  stim_row_t        dir_tab[$];

  bit idle_on = 1'b0;
  int rx_stall = 0;
  int idle_cycles = 0;
  int n_items = 0;
  int n_entries = 0;
  int n_errors = 0;
  int n_splits = 0;
  int n_eot = 0;
  int n_mismatch = 0;
  int n_unexpected = 0;
  result_t got_res;
  result_t want_res;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic result_t mk_res(logic [31:0] addr, logic [15:0] bytes, bit eot,
                                     status_e st, bit last);
    result_t r;
    r.entry_address = addr;
    r.entry_bytes   = bytes;
    r.end_of_table  = eot;
    r.status        = st;
    r.last_of_run   = last;
    return r;
  endfunction

  function automatic stim_row_t mk_row(kind_e k, int unsigned sec, logic [39:0] addr,
                                       int unsigned len, bit last, bit typed = 1'b0,
                                       int n = 0, result_t res = '0);
    stim_row_t r;
    r.it.kind         = k;
    r.it.sector_count = SECTOR_COUNT_W'(sec);
    r.it.phys_address = addr;
    r.it.pair_bytes   = PAIR_BYTES_W'(len);
    r.it.last_pair    = last;
    r.typed           = typed;
    r.n_typed         = n;
    r.res             = res;
    return r;
  endfunction

  task automatic predict_entries(input item_t it, input bit record);
    logic [63:0] addr;
    logic [63:0] len;
    logic [63:0] budget;
    logic [63:0] clip;
    logic [63:0] first;
    logic [63:0] bmask;
    status_e     st;
    addr  = 64'(it.phys_address);
    len   = 64'(it.pair_bytes);
    bmask = (64'd1 << BOUNDARY_LOG2) - 64'd1;
    if (it.kind == KIND_START) begin
      budget    = 64'(it.sector_count) * 64'(SECTOR_BYTES);
      budget_q  = (budget > 64'(BUDGET_MAX)) ? BUDGET_MAX : REM_W'(budget);
      aborted_q = 1'b0;
      return;
    end
    if (aborted_q) return;
    st = ST_OK;
    if (addr >= (64'd1 << ADDR_LIMIT_BITS)) st = ST_ADDR_HIGH;
    else if ((addr & 64'(ALIGN_MASK)) != 0) st = ST_MISALIGNED;
    else if (len > 64'(MAX_SPAN)) st = ST_SPAN_LARGE;
    else if ((len & 64'(ALIGN_MASK)) != 0) st = ST_MISALIGNED;
    if (st != ST_OK) begin
      aborted_q = 1'b1;
      if (record) entry_q.push_back(mk_res('0, '0, 1'b0, st, 1'b1));
      return;
    end
    clip = (len < 64'(budget_q)) ? len : 64'(budget_q);
    if (clip == 0) return;
    budget_q = budget_q - REM_W'(clip);
    first = (bmask + 64'd1) - (addr & bmask);
    if (!record) return;
    if (clip > first) begin
      n_splits++;
      entry_q.push_back(mk_res(32'(addr), 16'(first), 1'b0, ST_OK, 1'b0));
      entry_q.push_back(mk_res(32'(addr + first), 16'(clip - first), it.last_pair,
                               ST_OK, 1'b1));
    end else begin
      entry_q.push_back(mk_res(32'(addr), 16'(clip), it.last_pair, ST_OK, 1'b1));
    end
  endtask

  task automatic send_item(input stim_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({row.it.pair_bytes, row.it.phys_address,
                                    row.it.sector_count});
    s_axis_tuser_i  <= row.it.kind;
    s_axis_tlast_i  <= row.it.last_pair;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_items++;
    if (row.typed) begin
      predict_entries(row.it, 1'b0);
      if (row.n_typed > 0) entry_q.push_back(row.res);
    end else begin
      predict_entries(row.it, 1'b1);
    end
  endtask

  function automatic stim_row_t rand_pair(bit last);
    logic [39:0] addr;
    int unsigned len;
    int          r;
    addr = 40'($urandom);
    if ($urandom_range(0, 9) < 3) addr[15:0] = 16'(0 - $urandom_range(2, 1024));
    addr = addr & ~40'(ALIGN_MASK);
    r = $urandom_range(0, 99);
    if (r < 15) len = MAX_SPAN;
    else if (r < 25) len = $urandom_range(0, 64);
    else len = $urandom_range(0, MAX_SPAN);
    len = len & ~int'(ALIGN_MASK);
    r = $urandom_range(0, 99);
    if (r < 4) addr[39:32] = 8'($urandom_range(1, 255));
    else if (r < 8) addr[ALIGN_LOG2-1:0] = ALIGN_LOG2'($urandom_range(1, (1 << ALIGN_LOG2) - 1));
    else if (r < 12) len = $urandom_range(MAX_SPAN + 1, (1 << PAIR_BYTES_W) - 1);
    else if (r < 15) len = len | 1;
    return mk_row(KIND_PAIR, $urandom, addr, len, last);
  endfunction

  task automatic run_transfer();
    int unsigned sec;
    int          npairs;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 10) sec = $urandom_range(0, (1 << SECTOR_COUNT_W) - 1);
    else if (r < 25) sec = $urandom_range(128, 1024);
    else sec = $urandom_range(1, 64);
    send_item(mk_row(KIND_START, sec, 40'({$urandom, $urandom}), $urandom, 1'($urandom)));
    npairs = $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) npairs++;
    for (int i = 0; i < npairs; i++) begin
      send_item(rand_pair(i == npairs - 1 || ($urandom_range(0, 19) == 0)));
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall <= pick_gap();
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end

    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end

    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_res.entry_address = m_axis_tdata_o[ENTRY_ADDR_W-1:0];
      got_res.entry_bytes   = m_axis_tdata_o[ENTRY_ADDR_W +: ENTRY_BYTES_W];
      got_res.end_of_table  = m_axis_tdata_o[ENTRY_ADDR_W + ENTRY_BYTES_W];
      got_res.status        = status_e'(m_axis_tuser_o);
      got_res.last_of_run   = m_axis_tlast_o;
      n_entries++;
      if (got_res.status != ST_OK) n_errors++;
      if (got_res.end_of_table) n_eot++;
      if (entry_q.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= 10) begin
          $display("unexpected result at %0t: addr %h bytes %h eot %b status %0d last %b",
                   $realtime, got_res.entry_address, got_res.entry_bytes,
                   got_res.end_of_table, got_res.status, got_res.last_of_run);
        end
      end else begin
        want_res = entry_q.pop_front();
        if (got_res !== want_res) begin
          n_mismatch++;
          if (n_mismatch + n_unexpected <= 10) begin
            $display("mismatch at %0t: expected addr %h bytes %h eot %b status %0d last %b",
                     $realtime, want_res.entry_address, want_res.entry_bytes,
                     want_res.end_of_table, want_res.status, want_res.last_of_run);
            $display("                 actual   addr %h bytes %h eot %b status %0d last %b",
                     got_res.entry_address, got_res.entry_bytes, got_res.end_of_table,
                     got_res.status, got_res.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h1000, 'h200, 1'b1, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_START, 0, 40'h0, 0, 1'b0, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h0, 2, 1'b1, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_START, 'hFFFF, 40'h0, 0, 1'b0, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h00_FFFF_FFFE, 2, 1'b0, 1'b1, 1,
                             mk_res(32'hFFFF_FFFE, 16'd2, 1'b0, ST_OK, 1'b1)));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h0, MAX_SPAN, 1'b0, 1'b1, 1,
                             mk_res(32'h0, 16'h0, 1'b0, ST_OK, 1'b1)));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h1_2340, 'h10000, 1'b1));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h4000, 0, 1'b1, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h1_0000_0000, 'h100, 1'b0, 1'b1, 1,
                             mk_res('0, '0, 1'b0, ST_ADDR_HIGH, 1'b1)));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h2000, 'h100, 1'b1, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_START, 1, 40'h0, 0, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h101, 'h100, 1'b0, 1'b1, 1,
                             mk_res('0, '0, 1'b0, ST_MISALIGNED, 1'b1)));
    dir_tab.push_back(mk_row(KIND_START, 8, 40'h0, 0, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h0, MAX_SPAN + 2, 1'b0, 1'b1, 1,
                             mk_res('0, '0, 1'b0, ST_SPAN_LARGE, 1'b1)));
    dir_tab.push_back(mk_row(KIND_START, 8, 40'h0, 0, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h200, 3, 1'b1, 1'b1, 1,
                             mk_res('0, '0, 1'b0, ST_MISALIGNED, 1'b1)));
    dir_tab.push_back(mk_row(KIND_START, 4, 40'h0, 0, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'hFFC0, 'h1000, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h2000, 'h100, 1'b1, 1'b1, 0));
    dir_tab.push_back(mk_row(KIND_START, 16, 40'h0, 0, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h8000, 'h800, 1'b1));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h9000, 'h200, 1'b0));
    dir_tab.push_back(mk_row(KIND_PAIR, 'hFFFF, 40'hFF_FFFF_FFFF, 'hFFFFF, 1'b1, 1'b1, 1,
                             mk_res('0, '0, 1'b0, ST_ADDR_HIGH, 1'b1)));
    dir_tab.push_back(mk_row(KIND_START, 2, 40'hFF_FFFF_FFFF, 'hFFFFF, 1'b1));
    dir_tab.push_back(mk_row(KIND_PAIR, 0, 40'h1_FFFE, 4, 1'b1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i]);
    while (n_items < dir_tab.size() + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 2) idle_on = !idle_on;
      run_transfer();
    end
    s_axis_tvalid_i <= 1'b0;

    while (entry_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d input transactions, %0d results (%0d errors, %0d split pairs, %0d end marks)",
             n_items, n_entries, n_errors, n_splits, n_eot);
    $display("%0d mismatches, %0d unexpected results", n_mismatch, n_unexpected);
    if (n_mismatch == 0 && n_unexpected == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ dma_prd_table_builder_unit.f @@
src/dpt_pkg.sv
src/dpt_calc.sv
src/dma_prd_table_builder_unit.sv
tb/sv/dma_prd_table_builder_unit_test.sv
